// ----- design/http_request_head_parser_top_macros.svh -----
// Assertion macros shared by the request head parser checker.
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/hrp_pkg.sv -----
// Package with shared types and constants of the request head parser.
package hrp_pkg;

  localparam logic [15:0] LineCapReset = 16'd1024;
  localparam logic [15:0] HdrCapReset  = 16'd4096;
  localparam int unsigned NameLen      = 14;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChColon = 8'h3a;

  // Register indexes.
  localparam logic [0:0] RegLineCap = 1'b0;
  localparam logic [0:0] RegHdrCap  = 1'b1;

  // Token kinds.
  localparam logic [2:0] KindNone  = 3'd0;
  localparam logic [2:0] KindMeth  = 3'd1;
  localparam logic [2:0] KindUri   = 3'd2;
  localparam logic [2:0] KindProto = 3'd3;
  localparam logic [2:0] KindKey   = 3'd4;
  localparam logic [2:0] KindValue = 3'd5;

  // Status codes.
  localparam logic [1:0] StPending = 2'd0;
  localparam logic [1:0] StDone    = 2'd1;
  localparam logic [1:0] StError   = 2'd2;

  // Error codes.
  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrMeth  = 3'd1;
  localparam logic [2:0] ErrUri   = 3'd2;
  localparam logic [2:0] ErrProto = 3'd3;
  localparam logic [2:0] ErrHdr   = 3'd4;
  localparam logic [2:0] ErrBad   = 3'd5;

  // One result word.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        tok_valid;
    logic [2:0]  token_kind;
    logic        token_end;
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [31:0] length_out;
    logic [15:0] headers_out;
    logic        last;
  } res_t;

  // What the front hands to the back for one byte: up to two results.
  typedef struct packed {
    logic second;
    res_t r0;
    res_t r1;
  } pair_t;

  // Lower-case letter of the header name to match.
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0: c = "c";
        4'd1: c = "o";
        4'd2: c = "n";
        4'd3: c = "t";
        4'd4: c = "e";
        4'd5: c = "n";
        4'd6: c = "t";
        4'd7: c = "-";
        4'd8: c = "l";
        4'd9: c = "e";
        4'd10: c = "n";
        4'd11: c = "g";
        4'd12: c = "t";
        4'd13: c = "h";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

// ----- design/hrp_front.sv -----
// Front part: walks the phases of the head for each accepted byte.
module hrp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_idx,
  input  logic [15:0]          cfg_data,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output hrp_pkg::pair_t       pair
);

  typedef enum logic [2:0] {
    PH_METHOD, PH_URI, PH_PROTO, PH_KEY, PH_SPACE, PH_VALUE, PH_LASTLF, PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [15:0] line_cap_r, hdr_cap_r;
  logic [15:0] line_bytes_r, line_bytes_nxt;
  logic [15:0] hdr_bytes_r, hdr_bytes_nxt;
  logic [4:0]  key_len_r, key_len_nxt;
  logic        key_is_len_r, key_is_len_nxt;
  logic        cr_held_r, cr_held_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [15:0] htot_r, htot_nxt;

  logic [7:0]  low_b;
  logic        is_digit;
  logic [3:0]  digit;
  logic        acc_over;
  logic [31:0] acc_mul;
  logic        cr_is_bad;

  // Folded byte and decimal step of the value accumulator.
  always_comb begin
    low_b    = (byte_in >= "A" && byte_in <= "Z") ? byte_in + 8'd32 : byte_in;
    is_digit = byte_in >= "0" && byte_in <= "9";
    digit    = 4'(byte_in - "0");
    acc_over = (acc_r > 32'd429496729) || (acc_r == 32'd429496729 && digit > 4'd5);
    acc_mul  = (acc_r << 3) + (acc_r << 1) + 32'(digit);
    cr_is_bad = 1'b1;
  end

  function automatic hrp_pkg::res_t mk(input logic [7:0] b, input logic v,
                                       input logic [2:0] k, input logic e);
    hrp_pkg::res_t r;
    begin
      r = '0;
      r.byte_out = b;
      r.tok_valid = v;
      r.token_kind = k;
      r.token_end = e;
      return r;
    end
  endfunction

  function automatic hrp_pkg::res_t mk_err(input logic [2:0] c);
    hrp_pkg::res_t r;
    begin
      r = '0;
      r.status = hrp_pkg::StError;
      r.error_code = c;
      return r;
    end
  endfunction

  // Next state and result pair for the current byte.
  always_comb begin
    hrp_pkg::res_t ra, rb;
    logic n2;
    phase_nxt = phase_r; err_nxt = err_r;
    line_bytes_nxt = line_bytes_r; hdr_bytes_nxt = hdr_bytes_r;
    key_len_nxt = key_len_r; key_is_len_nxt = key_is_len_r;
    cr_held_nxt = cr_held_r; acc_nxt = acc_r; bad_nxt = bad_r;
    clen_nxt = clen_r; htot_nxt = htot_r;
    ra = '0; rb = '0; n2 = 1'b0;
    unique case (phase_r)
      PH_METHOD, PH_URI: begin
        if (byte_in == hrp_pkg::ChSpace) begin
          ra = mk(8'd0, 1'b0, (phase_r == PH_METHOD) ? hrp_pkg::KindMeth
                                                     : hrp_pkg::KindUri, 1'b1);
          phase_nxt = (phase_r == PH_METHOD) ? PH_URI : PH_PROTO;
        end else if (line_bytes_r >= line_cap_r) begin
          err_nxt = (phase_r == PH_METHOD) ? hrp_pkg::ErrMeth : hrp_pkg::ErrUri;
          ra = mk_err(err_nxt);
          phase_nxt = PH_ERROR;
        end else begin
          line_bytes_nxt = line_bytes_r + 16'd1;
          ra = mk(byte_in, 1'b1, (phase_r == PH_METHOD) ? hrp_pkg::KindMeth
                                                        : hrp_pkg::KindUri, 1'b0);
        end
      end
      PH_PROTO: begin
        if (byte_in == hrp_pkg::ChLf) begin
          ra = mk(8'd0, 1'b0, hrp_pkg::KindProto, 1'b1);
          phase_nxt = PH_KEY;
          key_len_nxt = '0; key_is_len_nxt = 1'b1; cr_held_nxt = 1'b0;
          acc_nxt = '0; bad_nxt = 1'b0;
        end else begin
          if (line_bytes_r >= line_cap_r) begin
            err_nxt = hrp_pkg::ErrProto;
            phase_nxt = PH_ERROR;
            cr_held_nxt = 1'b0;
            rb = mk_err(hrp_pkg::ErrProto);
          end else begin
            line_bytes_nxt = line_bytes_r + 16'd1;
            cr_held_nxt = byte_in == hrp_pkg::ChCr;
            rb = (byte_in == hrp_pkg::ChCr) ? '0
                 : mk(byte_in, 1'b1, hrp_pkg::KindProto, 1'b0);
          end
          if (cr_held_r) begin
            ra = mk(hrp_pkg::ChCr, 1'b1, hrp_pkg::KindProto, 1'b0);
            n2 = !(rb == '0);
          end else begin
            ra = rb;
          end
        end
      end
      PH_KEY: begin
        if (key_len_r == '0 && byte_in == hrp_pkg::ChCr) begin
          phase_nxt = PH_LASTLF;
        end else if (key_len_r == '0 && byte_in == hrp_pkg::ChLf) begin
          ra = '0; ra.status = hrp_pkg::StDone;
          ra.length_out = clen_r; ra.headers_out = htot_r;
          phase_nxt = PH_METHOD; line_bytes_nxt = '0; hdr_bytes_nxt = '0;
          clen_nxt = '0; htot_nxt = '0; key_len_nxt = '0; key_is_len_nxt = 1'b1;
          cr_held_nxt = 1'b0; acc_nxt = '0; bad_nxt = 1'b0;
        end else if (byte_in == hrp_pkg::ChColon) begin
          key_is_len_nxt = key_is_len_r && key_len_r == 5'(hrp_pkg::NameLen);
          ra = mk(8'd0, 1'b0, hrp_pkg::KindKey, 1'b1);
          phase_nxt = PH_SPACE;
        end else if (hdr_bytes_r >= hdr_cap_r) begin
          err_nxt = hrp_pkg::ErrHdr; ra = mk_err(hrp_pkg::ErrHdr);
          phase_nxt = PH_ERROR; cr_held_nxt = 1'b0;
        end else begin
          hdr_bytes_nxt = hdr_bytes_r + 16'd1;
          if (key_len_r >= 5'(hrp_pkg::NameLen) ||
              low_b != hrp_pkg::name_char(key_len_r[3:0]))
            key_is_len_nxt = 1'b0;
          if (key_len_r < 5'd31) key_len_nxt = key_len_r + 5'd1;
          ra = mk(byte_in, 1'b1, hrp_pkg::KindKey, 1'b0);
        end
      end
      PH_SPACE, PH_VALUE: begin
        phase_nxt = PH_VALUE;
        if (phase_r == PH_SPACE && byte_in == hrp_pkg::ChSpace) begin
          ra = '0;
        end else if (byte_in == hrp_pkg::ChLf) begin
          cr_held_nxt = 1'b0;
          if (key_is_len_r && (bad_r || cr_held_r)) begin
            // A held CR counts as a non-digit here only when emitted, so
            // it is not part of the value yet.
            if (bad_r) begin
              err_nxt = hrp_pkg::ErrBad; ra = mk_err(hrp_pkg::ErrBad);
              phase_nxt = PH_ERROR;
            end else begin
              clen_nxt = acc_r;
              if (htot_r != 16'hffff) htot_nxt = htot_r + 16'd1;
              ra = mk(8'd0, 1'b0, hrp_pkg::KindValue, 1'b1);
              phase_nxt = PH_KEY;
              key_len_nxt = '0; key_is_len_nxt = 1'b1; acc_nxt = '0; bad_nxt = 1'b0;
            end
          end else begin
            if (key_is_len_r) clen_nxt = acc_r;
            if (htot_r != 16'hffff) htot_nxt = htot_r + 16'd1;
            ra = mk(8'd0, 1'b0, hrp_pkg::KindValue, 1'b1);
            phase_nxt = PH_KEY;
            key_len_nxt = '0; key_is_len_nxt = 1'b1; acc_nxt = '0; bad_nxt = 1'b0;
          end
        end else begin
          // A held CR that is emitted late makes the value bad.
          if (cr_held_r) bad_nxt = cr_is_bad;
          if (hdr_bytes_r >= hdr_cap_r) begin
            err_nxt = hrp_pkg::ErrHdr; rb = mk_err(hrp_pkg::ErrHdr);
            phase_nxt = PH_ERROR; cr_held_nxt = 1'b0;
          end else begin
            hdr_bytes_nxt = hdr_bytes_r + 16'd1;
            cr_held_nxt = byte_in == hrp_pkg::ChCr;
            if (byte_in == hrp_pkg::ChCr) begin
              rb = '0;
            end else begin
              rb = mk(byte_in, 1'b1, hrp_pkg::KindValue, 1'b0);
              if (!is_digit || acc_over) bad_nxt = 1'b1;
              else if (!(cr_held_r || bad_r)) acc_nxt = acc_mul;
              else if (!cr_held_r) acc_nxt = acc_mul;
            end
          end
          if (cr_held_r) begin
            ra = mk(hrp_pkg::ChCr, 1'b1, hrp_pkg::KindValue, 1'b0);
            n2 = !(rb == '0);
          end else begin
            ra = rb;
          end
        end
      end
      PH_LASTLF: begin
        if (byte_in == hrp_pkg::ChLf) begin
          ra = '0; ra.status = hrp_pkg::StDone;
          ra.length_out = clen_r; ra.headers_out = htot_r;
          phase_nxt = PH_METHOD; line_bytes_nxt = '0; hdr_bytes_nxt = '0;
          clen_nxt = '0; htot_nxt = '0; key_len_nxt = '0; key_is_len_nxt = 1'b1;
          cr_held_nxt = 1'b0; acc_nxt = '0; bad_nxt = 1'b0;
        end else begin
          err_nxt = hrp_pkg::ErrBad; ra = mk_err(hrp_pkg::ErrBad);
          phase_nxt = PH_ERROR;
        end
      end
      PH_ERROR: begin
        ra = mk_err(err_r);
      end
      default: ra = '0;
    endcase
    pair.second = n2;
    pair.r0 = ra;
    pair.r1 = rb;
    pair.r0.last = !n2;
    pair.r1.last = 1'b1;
  end

  // Request state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD; err_r <= hrp_pkg::ErrNone;
      line_cap_r <= hrp_pkg::LineCapReset; hdr_cap_r <= hrp_pkg::HdrCapReset;
      line_bytes_r <= '0; hdr_bytes_r <= '0; key_len_r <= '0;
      key_is_len_r <= 1'b1; cr_held_r <= 1'b0; acc_r <= '0; bad_r <= 1'b0;
      clen_r <= '0; htot_r <= '0;
    end else begin
      if (cfg_we && cfg_idx == hrp_pkg::RegLineCap) line_cap_r <= cfg_data;
      if (cfg_we && cfg_idx == hrp_pkg::RegHdrCap) hdr_cap_r <= cfg_data;
      if (step) begin
        phase_r <= phase_nxt; err_r <= err_nxt;
        line_bytes_r <= line_bytes_nxt; hdr_bytes_r <= hdr_bytes_nxt;
        key_len_r <= key_len_nxt; key_is_len_r <= key_is_len_nxt;
        cr_held_r <= cr_held_nxt; acc_r <= acc_nxt; bad_r <= bad_nxt;
        clen_r <= clen_nxt; htot_r <= htot_nxt;
      end
    end
  end

endmodule

// ----- design/hrp_queue.sv -----
// Short queue of result pairs between front and back.
module hrp_queue #(
  parameter int unsigned Depth = hrp_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  hrp_pkg::pair_t wdata,
  output logic           full,
  input  logic           rd,
  output hrp_pkg::pair_t rdata,
  output logic           empty
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  hrp_pkg::pair_t   mem_r [Depth];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full  = cnt_r == (AW+1)'(Depth);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ----- design/hrp_back.sv -----
// Back part: hands out one or two result words per queued pair.
module hrp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  hrp_pkg::pair_t pair,
  output logic           rd,
  output logic           out_valid,
  input  logic           out_ready,
  output hrp_pkg::res_t  res
);

  logic sel_r;

  assign out_valid = !empty;
  assign res = sel_r ? pair.r1 : pair.r0;
  assign rd  = out_valid && out_ready && (sel_r || !pair.second);

  // Which word of the pair is shown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      sel_r <= !sel_r && pair.second;
    end
  end

endmodule

// ----- design/http_request_head_parser_top.sv -----
// Top level of the request head parser.
// A byte's result words are registered in the queue before they reach the output.
// Throughput: one byte per cycle while the queue is not full; a byte with two result words takes two out.
// Set by the per-byte phase logic in the front and the four-entry queue.
// Reset is synchronous, active low, and restores capacities and clears state.
module http_request_head_parser_top #(
  parameter int unsigned QDepth = hrp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic        out_tok_valid,
  output logic [2:0]  out_token_kind,
  output logic        out_token_end,
  output logic [1:0]  out_status,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_length_out,
  output logic [15:0] out_headers_out,
  output logic        out_last
);

  hrp_pkg::pair_t pair, qdata;
  hrp_pkg::res_t  res;
  logic full, empty, rd, step;

  assign in_ready = !full;
  assign step = in_valid && in_ready;

  hrp_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .step, .byte_in(in_byte_in), .pair
  );

  hrp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .wr(step), .wdata(pair), .full,
    .rd, .rdata(qdata), .empty
  );

  hrp_back u_back (
    .clk, .rst_n, .empty, .pair(qdata), .rd, .out_valid, .out_ready, .res
  );

  assign out_byte_out    = res.byte_out;
  assign out_tok_valid   = res.tok_valid;
  assign out_token_kind  = res.token_kind;
  assign out_token_end   = res.token_end;
  assign out_status      = res.status;
  assign out_error_code  = res.error_code;
  assign out_length_out  = res.length_out;
  assign out_headers_out = res.headers_out;
  assign out_last        = res.last;

endmodule

// ----- design/hrp_checker.sv -----
// Checker on the top level ports, with its bind.
`include "http_request_head_parser_top_macros.svh"
module hrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tok_valid,
  input logic        out_token_end,
  input logic [1:0]  out_status,
  input logic [2:0]  out_error_code,
  input logic        out_last
);
  `HRP_ASSERT_IMP(a_err_code, clk, rst_n, out_valid && out_status != hrp_pkg::StError,
                  out_error_code == hrp_pkg::ErrNone)
  `HRP_ASSERT_IMP(a_end_no_byte, clk, rst_n, out_valid && out_token_end, !out_tok_valid)
  `HRP_ASSERT_IMP(a_status_last, clk, rst_n, out_valid && out_status != hrp_pkg::StPending,
                  out_last)
  `HRP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind http_request_head_parser_top hrp_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_tok_valid, .out_token_end,
  .out_status, .out_error_code, .out_last
);

// ----- tb/http_request_head_parser_checker.sv -----
// Checker for the request head parser: predicts every result word and compares.
`timescale 1ns / 100ps

module http_request_head_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte_out,
  input  logic        out_tok_valid,
  input  logic [2:0]  out_token_kind,
  input  logic        out_token_end,
  input  logic [1:0]  out_status,
  input  logic [2:0]  out_error_code,
  input  logic [31:0] out_length_out,
  input  logic [15:0] out_headers_out,
  input  logic        out_last,
  output int          failures,
  output int          pending
);

  typedef enum logic [3:0] {
    PhMethod, PhUri, PhProto, PhKey, PhSpace, PhValue, PhLastLf, PhError
  } parse_phase_t;

  // Parser state as the block should hold it.
  parse_phase_t phase;
  logic [2:0]  err_code;
  logic [15:0] line_bytes, header_bytes, line_cap, header_cap;
  logic [4:0]  key_len;
  logic        key_is_length, cr_held, value_bad;
  logic [31:0] value_acc, content_len;
  logic [15:0] header_total;

  hrp_pkg::res_t expected_words[$];
  string length_name = "content-length";

  task automatic clear_field();
    key_len = '0;
    key_is_length = 1'b1;
    cr_held = 1'b0;
    value_acc = '0;
    value_bad = 1'b0;
  endtask

  task automatic clear_request();
    phase = PhMethod;
    line_bytes = '0;
    header_bytes = '0;
    content_len = '0;
    header_total = '0;
    clear_field();
  endtask

  task automatic emit(input logic [7:0] b, input logic v, input logic [2:0] kind,
                      input logic tend, input logic [1:0] st, input logic [2:0] err,
                      input logic [31:0] len, input logic [15:0] hdrs);
    hrp_pkg::res_t w;
    w.byte_out = b;
    w.tok_valid = v;
    w.token_kind = kind;
    w.token_end = tend;
    w.status = st;
    w.error_code = err;
    w.length_out = len;
    w.headers_out = hdrs;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  // A pending word that carries a token byte or a token end.
  task automatic emit_tok(input logic [7:0] b, input logic v, input logic [2:0] kind,
                          input logic tend);
    emit(b, v, kind, tend, hrp_pkg::StPending, hrp_pkg::ErrNone, 32'd0, 16'd0);
  endtask

  task automatic raise_error(input logic [2:0] code);
    phase = PhError;
    err_code = code;
    cr_held = 1'b0;
    emit(8'd0, 1'b0, hrp_pkg::KindNone, 1'b0, hrp_pkg::StError, code, 32'd0, 16'd0);
  endtask

  task automatic finish_head();
    emit(8'd0, 1'b0, hrp_pkg::KindNone, 1'b0, hrp_pkg::StDone, hrp_pkg::ErrNone,
         content_len, header_total);
    clear_request();
  endtask

  // Accumulate one value byte of a possible content length.
  task automatic take_digit(input logic [7:0] b);
    logic [31:0] d;
    if (b >= "0" && b <= "9") begin
      d = {24'd0, b} - 32'd48;
      if (value_acc > 32'd429496729 || (value_acc == 32'd429496729 && d > 32'd5))
        value_bad = 1'b1;
      else
        value_acc = value_acc * 32'd10 + d;
    end else begin
      value_bad = 1'b1;
    end
  endtask

  // Work out the result words of one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    int start;
    logic [2:0] kind;
    logic [7:0] folded;
    hrp_pkg::res_t w;
    start = expected_words.size();
    case (phase)
      PhMethod, PhUri: begin
        kind = (phase == PhMethod) ? hrp_pkg::KindMeth : hrp_pkg::KindUri;
        if (b == hrp_pkg::ChSpace) begin
          emit_tok(8'd0, 1'b0, kind, 1'b1);
          phase = (phase == PhMethod) ? PhUri : PhProto;
        end else if (line_bytes >= line_cap) begin
          raise_error((kind == hrp_pkg::KindMeth) ? hrp_pkg::ErrMeth : hrp_pkg::ErrUri);
        end else begin
          line_bytes++;
          emit_tok(b, 1'b1, kind, 1'b0);
        end
      end
      PhProto: begin
        if (b == hrp_pkg::ChLf) begin
          emit_tok(8'd0, 1'b0, hrp_pkg::KindProto, 1'b1);
          phase = PhKey;
          clear_field();
        end else begin
          if (cr_held) begin
            emit_tok(hrp_pkg::ChCr, 1'b1, hrp_pkg::KindProto, 1'b0);
            cr_held = 1'b0;
          end
          if (line_bytes >= line_cap) begin
            raise_error(hrp_pkg::ErrProto);
          end else begin
            line_bytes++;
            if (b == hrp_pkg::ChCr) cr_held = 1'b1;
            else emit_tok(b, 1'b1, hrp_pkg::KindProto, 1'b0);
          end
        end
      end
      PhKey: begin
        if (key_len == 5'd0 && b == hrp_pkg::ChCr) begin
          phase = PhLastLf;
        end else if (key_len == 5'd0 && b == hrp_pkg::ChLf) begin
          finish_head();
        end else if (b == hrp_pkg::ChColon) begin
          key_is_length = key_is_length && key_len == 5'(hrp_pkg::NameLen);
          emit_tok(8'd0, 1'b0, hrp_pkg::KindKey, 1'b1);
          phase = PhSpace;
        end else if (header_bytes >= header_cap) begin
          raise_error(hrp_pkg::ErrHdr);
        end else begin
          folded = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          header_bytes++;
          if (key_len >= 5'(hrp_pkg::NameLen) || folded != length_name[key_len])
            key_is_length = 1'b0;
          if (key_len < 5'd31) key_len++;
          emit_tok(b, 1'b1, hrp_pkg::KindKey, 1'b0);
        end
      end
      PhSpace, PhValue: begin
        // One space straight after the colon is dropped.
        if (!(phase == PhSpace && b == hrp_pkg::ChSpace)) begin
          if (b == hrp_pkg::ChLf) begin
            cr_held = 1'b0;
            if (key_is_length && value_bad) begin
              raise_error(hrp_pkg::ErrBad);
            end else begin
              if (key_is_length) content_len = value_acc;
              if (header_total != 16'hffff) header_total++;
              emit_tok(8'd0, 1'b0, hrp_pkg::KindValue, 1'b1);
              clear_field();
              phase = PhKey;
            end
          end else begin
            if (cr_held) begin
              emit_tok(hrp_pkg::ChCr, 1'b1, hrp_pkg::KindValue, 1'b0);
              take_digit(hrp_pkg::ChCr);
              cr_held = 1'b0;
            end
            if (header_bytes >= header_cap) begin
              raise_error(hrp_pkg::ErrHdr);
            end else begin
              header_bytes++;
              if (b == hrp_pkg::ChCr) begin
                cr_held = 1'b1;
              end else begin
                take_digit(b);
                emit_tok(b, 1'b1, hrp_pkg::KindValue, 1'b0);
              end
            end
          end
        end
        if (phase == PhSpace) phase = PhValue;
      end
      PhLastLf: begin
        if (b == hrp_pkg::ChLf) finish_head();
        else raise_error(hrp_pkg::ErrBad);
      end
      default: emit(8'd0, 1'b0, hrp_pkg::KindNone, 1'b0, hrp_pkg::StError, err_code,
                    32'd0, 16'd0);
    endcase
    if (expected_words.size() == start)
      emit_tok(8'd0, 1'b0, hrp_pkg::KindNone, 1'b0);
    w = expected_words[expected_words.size() - 1];
    w.last = 1'b1;
    expected_words[expected_words.size() - 1] = w;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Predict on input words, then compare output words in arrival order.
  always @(posedge clk) begin
    hrp_pkg::res_t want;
    if (!rst_n) begin
      line_cap = hrp_pkg::LineCapReset;
      header_cap = hrp_pkg::HdrCapReset;
      err_code = hrp_pkg::ErrNone;
      clear_request();
      expected_words.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == hrp_pkg::RegLineCap) line_cap = cfg_data;
        else header_cap = cfg_data;
      end
      if (in_valid && in_ready) parse_byte(in_byte_in);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected");
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("byte_out", want.byte_out, out_byte_out);
          check_field("tok_valid", want.tok_valid, out_tok_valid);
          check_field("token_kind", want.token_kind, out_token_kind);
          check_field("token_end", want.token_end, out_token_end);
          check_field("status", want.status, out_status);
          check_field("error_code", want.error_code, out_error_code);
          check_field("length_out", want.length_out, out_length_out);
          check_field("headers_out", want.headers_out, out_headers_out);
          check_field("last", want.last, out_last);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- tb/http_request_head_parser_top_tb.sv -----
// Testbench top for the request head parser: stimulus, handshake timing and verdict.
`timescale 1ns / 100ps

module http_request_head_parser_top_tb;

  localparam int MaxCycles = 600000;
  localparam int TargetWords = 1600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = hrp_pkg::RegLineCap;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_out;
  logic        out_tok_valid;
  logic [2:0]  out_token_kind;
  logic        out_token_end;
  logic [1:0]  out_status;
  logic [2:0]  out_error_code;
  logic [31:0] out_length_out;
  logic [15:0] out_headers_out;
  logic        out_last;
  int          failures;
  int          pending;

  int  sent = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  held_off = 1'b0;
  logic [7:0] stream[$];

  http_request_head_parser_top dut (.*);

  http_request_head_parser_checker checker_i (.*);

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("http_request_head_parser_top_tb: done, errors");
      $finish;
    end
  end

  // Receiver: one long hold-off to fill the block, otherwise random stall bursts.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && sent >= 400) begin
        held_off = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  // Random token bytes over the full byte range, avoiding one or two excluded codes.
  task automatic add_random(input int n, input logic [7:0] ex_a, input logic [7:0] ex_b);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == ex_a || c == ex_b);
      stream.push_back(c);
    end
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 2) != 0) stream.push_back(hrp_pkg::ChCr);
    stream.push_back(hrp_pkg::ChLf);
  endtask

  // Drive the queued bytes, one word per handshake, with random sender gaps.
  task automatic send_stream();
    while (stream.size() != 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      in_valid = 1'b1;
      in_byte_in = stream.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent++;
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One well-formed request head with random content.
  task automatic add_request();
    string name;
    int nhdr;
    add_random($urandom_range(1, 6), hrp_pkg::ChSpace, hrp_pkg::ChSpace);
    stream.push_back(hrp_pkg::ChSpace);
    add_random($urandom_range(0, 20), hrp_pkg::ChSpace, hrp_pkg::ChSpace);
    stream.push_back(hrp_pkg::ChSpace);
    if ($urandom_range(0, 3) == 0) begin
      add_random($urandom_range(0, 6), hrp_pkg::ChLf, hrp_pkg::ChLf);
      if (stream[stream.size() - 1] == hrp_pkg::ChCr) stream.push_back("x");
    end else begin
      add_text("HTTP/1.1");
    end
    add_eol();
    nhdr = $urandom_range(0, 4);
    repeat (nhdr) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          name = "content-length";
          for (int i = 0; i < name.len(); i++)
            if (name[i] >= "a" && name[i] <= "z" && $urandom_range(0, 1))
              name[i] = name[i] - 8'd32;
          add_text(name);
          add_text(":");
          if ($urandom_range(0, 3) != 0) add_text(" ");
          case ($urandom_range(0, 3))
            0: add_text("4294967295");
            1: ;
            default: add_text($sformatf("%0d", $urandom_range(0, 99999)));
          endcase
        end
        2: begin
          if ($urandom_range(0, 1)) add_text("content-lengt");
          else add_text("Content-Lengthx");
          add_text(": ");
          add_random($urandom_range(0, 8), hrp_pkg::ChLf, hrp_pkg::ChLf);
        end
        default: begin
          // Key bytes may be anything but a colon, and not CR or LF first.
          if ($urandom_range(0, 7) != 0) begin
            add_random(1, hrp_pkg::ChCr, hrp_pkg::ChLf);
            if (stream[stream.size() - 1] == hrp_pkg::ChColon)
              stream[stream.size() - 1] = "k";
            add_random($urandom_range(0, 19), hrp_pkg::ChColon, hrp_pkg::ChColon);
          end
          add_text(":");
          if ($urandom_range(0, 1)) add_text(" ");
          add_random($urandom_range(0, 12), hrp_pkg::ChLf, hrp_pkg::ChLf);
        end
      endcase
      add_eol();
    end
    add_eol();
  endtask

  initial begin
    int code;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme bytes, held and late CRs, largest length, empty key and value.
    stream.push_back(8'hff);
    add_text(" ");
    stream.push_back(8'h00);
    add_text(" H");
    stream.push_back(hrp_pkg::ChCr);
    add_text("X");
    stream.push_back(hrp_pkg::ChCr);
    stream.push_back(hrp_pkg::ChLf);
    add_text("CONTENT-length:4294967295");
    stream.push_back(hrp_pkg::ChCr);
    stream.push_back(hrp_pkg::ChLf);
    add_text(":");
    stream.push_back(hrp_pkg::ChLf);
    stream.push_back(hrp_pkg::ChCr);
    stream.push_back(hrp_pkg::ChLf);
    add_text("A  \nContent-Length: \n\n");
    send_stream();

    // Random requests under two capacity settings.
    write_reg(hrp_pkg::RegLineCap, 16'hffff);
    write_reg(hrp_pkg::RegHdrCap, 16'hffff);
    while (sent < TargetWords / 2) begin
      add_request();
      send_stream();
    end
    write_reg(hrp_pkg::RegLineCap, 16'd60);
    write_reg(hrp_pkg::RegHdrCap, 16'd200);
    while (sent < TargetWords) begin
      if (sent > TargetWords * 9 / 10) quiet = 1'b1;
      add_request();
      send_stream();
    end

    // The error state holds until reset, so one error kind closes the run.
    code = $urandom_range(1, 5);
    if (code != 5) write_reg(hrp_pkg::RegLineCap, 16'd1);
    if (code == 4) write_reg(hrp_pkg::RegHdrCap, 16'd1);
    wait_idle();
    case (code)
      1: add_text("AB ");
      2: add_text("A BC");
      3: add_text("A  H");
      4: add_text("A  \nkk:v\n");
      default: add_text("A B H\ncontent-length: 1x\n");
    endcase
    add_random(30, hrp_pkg::ChSpace, hrp_pkg::ChSpace);
    send_stream();

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("http_request_head_parser_top_tb: done, clean");
    end else begin
      $display("http_request_head_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/hrp_pkg.sv
design/hrp_front.sv
design/hrp_queue.sv
design/hrp_back.sv
design/http_request_head_parser_top.sv
design/hrp_checker.sv
tb/http_request_head_parser_checker.sv
tb/http_request_head_parser_top_tb.sv
